// ===== rtl/sude16_pkg.sv =====
// Shared constants and types for the scaled unsigned divide by ten to the sixteenth.
package sude16_pkg;

    localparam int DATA_W = 64;
    localparam int PROD_W = 2 * DATA_W;
    localparam int STAT_W = 2;

    // Ten to the sixteenth needs 54 bits.
    localparam int SCALE_BITS = 54;
    localparam logic [SCALE_BITS-1:0] SCALE_E16 = SCALE_BITS'(64'd10000000000000000);

    localparam int CNT_W = 6;
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(SCALE_BITS - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DATA_W - 1);

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_DIV_ZERO = 2'd1;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_CHK  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

endpackage

// ===== rtl/scaled_unsigned_divide_by_e16.sv =====
// Top level: dividend times ten to the sixteenth, divided by the divisor.
// A zero divisor goes straight to the output load; an overflow passes through the multiply steps
// and the range check; a normal quotient takes 54 shift-add multiply steps, one range check,
// 64 restoring divide steps and one output load. One item is in work at a time, and the output
// load waits while the previous beat is still held by m_ready low.
// Reset (aresetn low, synchronous) returns the sequencer to idle and empties the output.
module scaled_unsigned_divide_by_e16 (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [sude16_pkg::DATA_W-1:0]  s_dividend,
    input  logic [sude16_pkg::DATA_W-1:0]  s_divisor,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [sude16_pkg::DATA_W-1:0]  m_quotient,
    output logic [sude16_pkg::STAT_W-1:0]  m_status
);

    sude16_pkg::state_t state_reg, state_next;
    logic [sude16_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic [sude16_pkg::PROD_W-1:0]     prod_reg, prod_next;
    logic [sude16_pkg::PROD_W-1:0]     mcand_reg, mcand_next;
    logic [sude16_pkg::SCALE_BITS-1:0] mult_reg, mult_next;
    logic [sude16_pkg::DATA_W-1:0]     div_reg, div_next;
    logic [sude16_pkg::DATA_W-1:0]     rem_reg, rem_next;
    logic [sude16_pkg::STAT_W-1:0]     stat_reg, stat_next;
    logic                              m_valid_reg, m_valid_next;
    logic [sude16_pkg::DATA_W-1:0]     m_quotient_reg, m_quotient_next;
    logic [sude16_pkg::STAT_W-1:0]     m_status_reg, m_status_next;

    logic [sude16_pkg::DATA_W-1:0]     shifted;
    logic [sude16_pkg::DATA_W:0]       diff;
    logic                              out_free;

    assign s_ready    = (state_reg == sude16_pkg::ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_quotient = m_quotient_reg;
    assign m_status   = m_status_reg;
    assign out_free   = !m_valid_reg || m_ready;

    // The product's low half shifts out its top bit into the remainder while quotient
    // bits shift in at the bottom, so the low half ends up holding the quotient.
    assign shifted = {rem_reg[sude16_pkg::DATA_W-2:0], prod_reg[sude16_pkg::DATA_W-1]};
    assign diff    = {rem_reg[sude16_pkg::DATA_W-1], shifted} - {1'b0, div_reg};

    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        prod_next       = prod_reg;
        mcand_next      = mcand_reg;
        mult_next       = mult_reg;
        div_next        = div_reg;
        rem_next        = rem_reg;
        stat_next       = stat_reg;
        m_valid_next    = m_valid_reg;
        m_quotient_next = m_quotient_reg;
        m_status_next   = m_status_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            sude16_pkg::ST_IDLE: begin
                if (s_valid) begin
                    div_next   = s_divisor;
                    prod_next  = '0;
                    mcand_next = {{sude16_pkg::DATA_W{1'b0}}, s_dividend};
                    mult_next  = sude16_pkg::SCALE_E16;
                    cnt_next   = sude16_pkg::MUL_LAST;
                    if (s_divisor == '0) begin
                        stat_next  = sude16_pkg::STAT_DIV_ZERO;
                        state_next = sude16_pkg::ST_OUT;
                    end else begin
                        stat_next  = sude16_pkg::STAT_OK;
                        state_next = sude16_pkg::ST_MUL;
                    end
                end
            end
            sude16_pkg::ST_MUL: begin
                if (mult_reg[0]) begin
                    prod_next = prod_reg + mcand_reg;
                end
                mcand_next = {mcand_reg[sude16_pkg::PROD_W-2:0], 1'b0};
                mult_next  = {1'b0, mult_reg[sude16_pkg::SCALE_BITS-1:1]};
                cnt_next   = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = sude16_pkg::ST_CHK;
                end
            end
            sude16_pkg::ST_CHK: begin
                rem_next = prod_reg[sude16_pkg::PROD_W-1:sude16_pkg::DATA_W];
                cnt_next = sude16_pkg::DIV_LAST;
                if (prod_reg[sude16_pkg::PROD_W-1:sude16_pkg::DATA_W] >= div_reg) begin
                    stat_next  = sude16_pkg::STAT_OVERFLOW;
                    state_next = sude16_pkg::ST_OUT;
                end else begin
                    state_next = sude16_pkg::ST_DIV;
                end
            end
            sude16_pkg::ST_DIV: begin
                if (!diff[sude16_pkg::DATA_W]) begin
                    rem_next = diff[sude16_pkg::DATA_W-1:0];
                end else begin
                    rem_next = shifted;
                end
                prod_next = {prod_reg[sude16_pkg::PROD_W-1:sude16_pkg::DATA_W],
                             prod_reg[sude16_pkg::DATA_W-2:0], !diff[sude16_pkg::DATA_W]};
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = sude16_pkg::ST_OUT;
                end
            end
            sude16_pkg::ST_OUT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = stat_reg;
                    case (stat_reg)
                        sude16_pkg::STAT_DIV_ZERO: m_quotient_next = '0;
                        sude16_pkg::STAT_OVERFLOW: m_quotient_next = '1;
                        default: m_quotient_next = prod_reg[sude16_pkg::DATA_W-1:0];
                    endcase
                    state_next = sude16_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sude16_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sude16_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        cnt_reg        <= cnt_next;
        prod_reg       <= prod_next;
        mcand_reg      <= mcand_next;
        mult_reg       <= mult_next;
        div_reg        <= div_next;
        rem_reg        <= rem_next;
        stat_reg       <= stat_next;
        m_quotient_reg <= m_quotient_next;
        m_status_reg   <= m_status_next;
    end

    // The partial remainder always stays below the divisor during division.
    a_rem_below_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sude16_pkg::ST_DIV) |-> (rem_reg < div_reg))
        else $error("partial remainder reached the divisor");

    a_zero_quotient: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg == sude16_pkg::STAT_DIV_ZERO) |-> (m_quotient_reg == '0))
        else $error("divide by zero beat carries a nonzero quotient");

    a_sat_quotient: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg == sude16_pkg::STAT_OVERFLOW) |-> (m_quotient_reg == '1))
        else $error("overflow beat is not saturated");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted again while an item is in work");

    a_valid_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == sude16_pkg::ST_OUT))
        else $error("result beat appeared outside the output load");

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the divider that scales a dividend by ten to the sixteenth.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [sude16_pkg::DATA_W-1:0] TEN_E16 = 64'd10000000000000000;
    localparam logic [sude16_pkg::DATA_W-1:0] ALL_ONES = {sude16_pkg::DATA_W{1'b1}};
    localparam logic [sude16_pkg::DATA_W-1:0] TOP_BIT =
        {1'b1, {(sude16_pkg::DATA_W-1){1'b0}}};
    localparam int CYCLE_LIMIT = 1500000;
    localparam int DRAIN_CYCLES = 130;

    typedef struct packed {
        logic [sude16_pkg::DATA_W-1:0] quot;
        logic [sude16_pkg::STAT_W-1:0] stat;
    } quot_beat_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic [sude16_pkg::DATA_W-1:0] s_dividend = '0;
    logic [sude16_pkg::DATA_W-1:0] s_divisor = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic [sude16_pkg::DATA_W-1:0] m_quotient;
    logic [sude16_pkg::STAT_W-1:0] m_status;

    quot_beat_t quotients_due[$];
    int         error_count = 0;
    int         cycle_count = 0;
    int         burst_left = 0;
    bit         no_gaps = 1'b0;
    int         ready_hold = 0;

    scaled_unsigned_divide_by_e16 dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_dividend (s_dividend),
        .s_divisor  (s_divisor),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_quotient (m_quotient),
        .m_status   (m_status)
    );

    always #5 aclk = ~aclk;

    function automatic logic [sude16_pkg::DATA_W-1:0] scaled_high(
            input logic [sude16_pkg::DATA_W-1:0] num);
        logic [sude16_pkg::PROD_W-1:0] prod;
        prod = {{sude16_pkg::DATA_W{1'b0}}, num} * {{sude16_pkg::DATA_W{1'b0}}, TEN_E16};
        return prod[sude16_pkg::PROD_W-1:sude16_pkg::DATA_W];
    endfunction

    function automatic quot_beat_t scaled_quotient(input logic [sude16_pkg::DATA_W-1:0] num,
                                                   input logic [sude16_pkg::DATA_W-1:0] den);
        logic [sude16_pkg::PROD_W-1:0] prod;
        logic [sude16_pkg::PROD_W-1:0] full_q;
        quot_beat_t                    res;
        prod = {{sude16_pkg::DATA_W{1'b0}}, num} * {{sude16_pkg::DATA_W{1'b0}}, TEN_E16};
        if (den == '0) begin
            res.quot = '0;
            res.stat = sude16_pkg::STAT_DIV_ZERO;
        end else if (prod[sude16_pkg::PROD_W-1:sude16_pkg::DATA_W] >= den) begin
            res.quot = ALL_ONES;
            res.stat = sude16_pkg::STAT_OVERFLOW;
        end else begin
            full_q = prod / {{sude16_pkg::DATA_W{1'b0}}, den};
            res.quot = full_q[sude16_pkg::DATA_W-1:0];
            res.stat = sude16_pkg::STAT_OK;
        end
        return res;
    endfunction

    function automatic logic [sude16_pkg::DATA_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [sude16_pkg::DATA_W-1:0] rand_sized();
        return rand_word() >> $urandom_range(0, sude16_pkg::DATA_W - 1);
    endfunction

    task automatic report_mismatch(input string what,
                                   input logic [sude16_pkg::DATA_W-1:0] got,
                                   input logic [sude16_pkg::DATA_W-1:0] want);
        $display("MISMATCH at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
        error_count++;
    endtask

    task automatic send_beat(input logic [sude16_pkg::DATA_W-1:0] num,
                             input logic [sude16_pkg::DATA_W-1:0] den);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (!no_gaps) begin
                gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
            end
        end
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_dividend <= num;
        s_divisor  <= den;
        do @(posedge aclk); while (!s_ready);
        quotients_due.push_back(scaled_quotient(num, den));
        burst_left--;
    endtask

    task automatic pause_until_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        burst_left = 0;
        while (quotients_due.size() != 0) @(posedge aclk);
    endtask

    task automatic test_corner_values();
        logic [sude16_pkg::DATA_W-1:0] num;
        logic [sude16_pkg::DATA_W-1:0] hi;
        send_beat('0, '0);
        send_beat('0, 64'd1);
        send_beat('0, ALL_ONES);
        send_beat(ALL_ONES, '0);
        send_beat(ALL_ONES, ALL_ONES);
        send_beat(ALL_ONES, 64'd1);
        send_beat(64'd1, 64'd1);
        send_beat(64'd1, TOP_BIT);
        send_beat(ALL_ONES, TOP_BIT);
        send_beat(ALL_ONES, TOP_BIT - 64'd1);
        send_beat(64'd12345, TEN_E16);
        send_beat(TEN_E16, TEN_E16);
        send_beat(64'd1844, 64'd1);
        send_beat(64'd1845, 64'd1);
        send_beat(rand_word(), rand_word() | TOP_BIT);
        repeat (3) begin
            num = rand_word() | TOP_BIT;
            hi = scaled_high(num);
            send_beat(num, hi);
            send_beat(num, hi + 64'd1);
        end
        send_beat(rand_word(), '0);
        send_beat('0, rand_word());
    endtask

    task automatic test_random_operands(input int count);
        logic [sude16_pkg::DATA_W-1:0] num;
        logic [sude16_pkg::DATA_W-1:0] den;
        repeat (count) begin
            num = rand_word();
            den = rand_word();
            case ($urandom_range(0, 9))
                2: den = den >> $urandom_range(40, sude16_pkg::DATA_W - 1);
                3: den = scaled_high(num) - 64'd1 + 64'($urandom_range(0, 3));
                4: den = den | TOP_BIT;
                5: if ($urandom_range(0, 3) == 0) den = '0;
                6: num = '0;
                7, 8, 9: begin
                    num = rand_sized();
                    den = rand_sized();
                end
                default: ;
            endcase
            send_beat(num, den);
        end
    endtask

    task automatic test_drain_pauses(input int rounds);
        repeat (rounds) begin
            repeat ($urandom_range(1, 6)) send_beat(rand_sized(), rand_sized());
            pause_until_drained();
        end
    endtask

    task automatic test_back_to_back(input int count);
        no_gaps = 1'b1;
        test_random_operands(count);
        no_gaps = 1'b0;
    endtask

    always @(negedge aclk) begin
        if (ready_hold == 0) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    m_ready <= 1'b1;
                    ready_hold = $urandom_range(1, 40);
                end
                5, 6, 7: begin
                    m_ready <= 1'b0;
                    ready_hold = $urandom_range(1, 5);
                end
                default: begin
                    m_ready <= 1'b0;
                    ready_hold = $urandom_range(10, 40);
                end
            endcase
        end else begin
            ready_hold--;
        end
    end

    always @(posedge aclk) begin
        quot_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (quotients_due.size() == 0) begin
                report_mismatch("unexpected beat, quotient", m_quotient, '0);
            end else begin
                want = quotients_due.pop_front();
                if (m_quotient !== want.quot) begin
                    report_mismatch("quotient", m_quotient, want.quot);
                end
                if (m_status !== want.stat) begin
                    report_mismatch("status", 64'(m_status), 64'(want.stat));
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles.", cycle_count);
            $display("scaled_unsigned_divide_by_e16 test failed");
            $finish;
        end
    end

    initial begin
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        test_corner_values();
        test_random_operands(1100);
        test_drain_pauses(40);
        test_back_to_back(400);
        test_random_operands(100);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (quotients_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0 && quotients_due.size() == 0) begin
            $display("scaled_unsigned_divide_by_e16 test passed");
        end else begin
            $display("scaled_unsigned_divide_by_e16 test failed");
        end
        $finish;
    end

endmodule
